/* sv/pdmc_pkg.sv */
// ----------------------------------------------------------------------------
// PID distance motor control package
// Shared widths, codes, reset values and the controller/datapath interface.
// ----------------------------------------------------------------------------
package pdmc_pkg;

   localparam int FULL_DUTY_DEF = 255;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int ERR_W = 17;
   localparam int EQ_W = 27;
   localparam int PROD_W = 43;
   localparam int DIVD_W = 43;
   localparam int DIVS_W = 16;
   localparam int DER_W = 38;
   localparam int INT_W = 32;
   localparam int MACX_W = 48;
   localparam int ACC_W = 80;
   localparam int SUM_W = 66;
   localparam int PID_W = 18;

   // Reciprocals for floor(x / 25) with x below 2^20 (shift 25) and
   // floor(x / 125) with x below 2^23 (shift 30).
   localparam logic [20:0] RECIP_25 = 21'd1342178;
   localparam logic [23:0] RECIP_125 = 24'd8589935;

   localparam logic [15:0] TARGET_RST = 16'd2000;
   localparam logic signed [31:0] FLOOR_RST = -32'sd6553600;
   localparam logic [30:0] CEIL_RST = 31'd6553600;
   localparam logic [15:0] TOL_RST = 16'd100;

   typedef enum logic [1:0] {
      OP_SAMPLE,
      OP_ACTIVATE,
      OP_DEACTIVATE,
      OP_ESTOP
   } op_type;

   typedef enum logic [2:0] {
      REG_TARGET,
      REG_GAIN_P,
      REG_GAIN_I,
      REG_GAIN_D,
      REG_INT_FLOOR,
      REG_INT_CEIL,
      REG_MIN_DUTY,
      REG_TOLERANCE
   } reg_index_type;

   localparam logic [1:0] DIR_STOP = 2'd0;
   localparam logic [1:0] DIR_FWD = 2'd1;
   localparam logic [1:0] DIR_REV = 2'd2;

   localparam logic [1:0] ST_INACTIVE = 2'd0;
   localparam logic [1:0] ST_ACTIVE = 2'd1;
   localparam logic [1:0] ST_EMERGENCY = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_EQ_MUL,
      S_EQ_LOAD,
      S_I_QUO,
      S_I_MUL,
      S_I_STEP,
      S_I_LOAD,
      S_D_MUL,
      S_D_START,
      S_D_DIV,
      S_MAC,
      S_SUM,
      S_CLAMP,
      S_FIN,
      S_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic load_in;
      logic decode;
      logic div_start;
      logic eq_mul;
      logic eq_load;
      logic iq_load;
      logic im_load;
      logic istep_load;
      logic int_load;
      logic prod_d_load;
      logic der_load;
      logic sum_clear;
      logic mac_step;
      logic sum_add;
      logic pid_load;
      logic fin_load;
      logic rsp_load;
      logic [1:0] term;
      logic [1:0] slice;
   } pdmc_cmd_type;

   typedef struct packed {
      logic div_done;
      logic run_pid;
   } pdmc_stat_type;

endpackage

/* sv/pdmc_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Carries one operation item: the operation code, a distance and elapsed time.
// ----------------------------------------------------------------------------
interface pdmc_req_if;
   logic valid;
   logic ready;
   logic [1:0] operation;
   logic [15:0] distance;
   logic [15:0] elapsed_ms;

   modport source (output valid, output operation, output distance,
                   output elapsed_ms, input ready);
   modport sink (input valid, input operation, input distance,
                 input elapsed_ms, output ready);
endinterface

/* sv/pdmc_rsp_if.sv */
// ----------------------------------------------------------------------------
// Response channel
// Carries one result item: duty, direction, control state and PID output.
// ----------------------------------------------------------------------------
interface pdmc_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] duty;
   logic [1:0] direction;
   logic [1:0] control_state;
   logic signed [8:0] pid_output;

   modport source (output valid, output duty, output direction,
                   output control_state, output pid_output, input ready);
   modport sink (input valid, input duty, input direction,
                 input control_state, input pid_output, output ready);
endinterface

/* sv/pdmc_div.sv */
// ----------------------------------------------------------------------------
// Signed divider
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module pdmc_div (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [pdmc_pkg::DIVD_W-1:0] dividend,
   input  logic [pdmc_pkg::DIVS_W-1:0] divisor,
   output logic done,
   output logic signed [pdmc_pkg::DIVD_W-1:0] quotient
);
   import pdmc_pkg::*;

   localparam int MAG_W = DIVD_W - 1;
   localparam int CNT_W = $clog2(MAG_W);

   logic busy_ff, done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic neg_ff;
   logic [MAG_W-1:0] mag_ff;
   logic [DIVS_W-1:0] rem_ff, div_ff;
   logic signed [DIVD_W-1:0] abs_in;
   logic [DIVS_W:0] rem_sh;
   logic qbit;
   logic [DIVS_W-1:0] rem_in;

   assign abs_in = dividend[DIVD_W-1] ? -dividend : dividend;
   assign rem_sh = {rem_ff, mag_ff[MAG_W-1]};
   assign qbit = rem_sh >= {1'b0, div_ff};
   assign rem_in = qbit ? DIVS_W'(rem_sh - {1'b0, div_ff}) : rem_sh[DIVS_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MAG_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[DIVD_W-1];
         mag_ff <= abs_in[MAG_W-1:0];
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         mag_ff <= {mag_ff[MAG_W-2:0], qbit};
      end
   end

   assign done = done_ff;
   assign quotient = neg_ff ? -$signed({1'b0, mag_ff}) : $signed({1'b0, mag_ff});
endmodule

/* sv/pdmc_datapath.sv */
// ----------------------------------------------------------------------------
// PID datapath
// Settings registers, controller state, divider, multiply-accumulate unit and
// the output shaping of duty and direction.
// ----------------------------------------------------------------------------
module pdmc_datapath #(
   parameter int FULL_DUTY = pdmc_pkg::FULL_DUTY_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [pdmc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pdmc_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic [1:0] in_operation,
   input  logic [15:0] in_distance,
   input  logic [15:0] in_elapsed_ms,
   input  pdmc_pkg::pdmc_cmd_type cmd,
   output pdmc_pkg::pdmc_stat_type stat,
   output logic [7:0] out_duty,
   output logic [1:0] out_direction,
   output logic [1:0] out_control_state,
   output logic signed [8:0] out_pid_output
);
   import pdmc_pkg::*;

   localparam logic signed [SUM_W-1:0] SUM_LIM = SUM_W'(FULL_DUTY) <<< 16;
   localparam logic signed [PID_W-1:0] PID_FULL = PID_W'(FULL_DUTY);
   localparam logic signed [PID_W-1:0] PID_MAX = PID_W'(255);
   localparam logic signed [10:0] K1000 = 11'sd1000;

   // Floor of x / 1000 for x below 2^26.
   function automatic logic [16:0] div_by_1000(logic [25:0] x);
      logic [46:0] p;
      p = 47'(x[25:3]) * 47'(RECIP_125);
      return p[46:30];
   endfunction

   logic [15:0] target_ff, tol_ff;
   logic signed [31:0] gp_ff, gi_ff, gd_ff, floor_ff;
   logic [30:0] ceil_ff;
   logic [7:0] mind_ff;

   logic [1:0] op_ff;
   logic [15:0] dist_ff, ms_ff;
   logic enabled_ff;
   logic [1:0] status_ff;
   logic signed [INT_W-1:0] integ_ff;
   logic signed [EQ_W-1:0] prev_ff, eq_ff;
   logic [7:0] hduty_ff;
   logic [1:0] hdir_ff;
   logic signed [8:0] hpid_ff;
   logic [15:0] eq_frac_ff;
   logic [16:0] qa_ff;
   logic [25:0] rm_ff;
   logic [32:0] qm_ff;
   logic signed [33:0] step_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [DER_W-1:0] der_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [PID_W-1:0] pid_ff;
   logic [7:0] duty_ff;
   logic [1:0] dir_ff, cst_ff;
   logic signed [8:0] pido_ff;

   logic signed [ERR_W-1:0] err_s;
   logic [15:0] ms_eff;
   logic [15:0] err_mag;
   logic [19:0] err_x9;
   logic [40:0] eq_rp;
   logic [25:0] eq_mag;
   logic [25:0] eq_abs;
   logic [9:0] ra;
   logic [32:0] step_mag;
   logic div_done;
   logic signed [DIVD_W-1:0] div_q;
   logic signed [EQ_W:0] diff;
   logic signed [EQ_W+11:0] mul_d;
   logic signed [PROD_W:0] int_sum, floor_x, ceil_x;
   logic signed [INT_W-1:0] int_in;
   logic signed [MACX_W-1:0] mac_x;
   logic signed [31:0] mac_g;
   logic signed [16:0] chunk;
   logic signed [48:0] pp;
   logic signed [ACC_W-1:0] pp_sh, acc_sh;
   logic signed [SUM_W-1:0] sum_cl, sum_rnd;
   logic signed [PID_W-1:0] mag1, mind_s, v1, v2, v3, mag3, tol_s, err_abs;
   logic [7:0] duty_in;
   logic [1:0] dir_in;
   logic signed [8:0] hpid_in;

   assign err_s = $signed({1'b0, target_ff}) - $signed({1'b0, dist_ff});
   assign ms_eff = (ms_ff == 16'd0) ? 16'd1 : ms_ff;
   assign stat = '{div_done: div_done, run_pid: (op_ff == OP_SAMPLE) && enabled_ff};

   // Error scaling: |err| * 65536 / 100 = 655 * |err| + floor(9 * |err| / 25).
   assign err_mag = err_s[ERR_W-1] ? 16'(-err_s) : err_s[15:0];
   assign err_x9 = 20'(err_mag) * 20'd9;
   assign eq_rp = 41'(err_x9) * 41'(RECIP_25);
   assign eq_mag = 26'(err_mag) * 26'd655 + 26'(eq_frac_ff);

   // Integral step: |eq| = 1000 * qa + ra, so |eq| * ms / 1000 is
   // qa * ms + floor(ra * ms / 1000).
   assign eq_abs = eq_ff[EQ_W-1] ? 26'(-eq_ff) : eq_ff[25:0];
   assign ra = 10'(eq_abs - 26'(qa_ff) * 26'd1000);
   assign step_mag = qm_ff + 33'(div_by_1000(rm_ff));

   pdmc_div u_div (
      .clock(clock),
      .reset(reset),
      .start(cmd.div_start),
      .dividend(prod_ff),
      .divisor(ms_eff),
      .done(div_done),
      .quotient(div_q)
   );

   assign diff = $signed({eq_ff[EQ_W-1], eq_ff}) - $signed({prev_ff[EQ_W-1], prev_ff});
   assign mul_d = diff * K1000;

   assign int_sum = (PROD_W+1)'(integ_ff) + (PROD_W+1)'(step_ff);
   assign floor_x = (PROD_W+1)'(floor_ff);
   assign ceil_x = (PROD_W+1)'($signed({1'b0, ceil_ff}));
   assign int_in = (int_sum < floor_x) ? floor_ff :
                   (int_sum > ceil_x) ? $signed({1'b0, ceil_ff}) :
                   int_sum[INT_W-1:0];

   always_comb begin
      case (cmd.term)
         2'd0: begin
            mac_x = MACX_W'(eq_ff);
            mac_g = gp_ff;
         end
         2'd1: begin
            mac_x = MACX_W'(integ_ff);
            mac_g = gi_ff;
         end
         default: begin
            mac_x = MACX_W'(der_ff);
            mac_g = gd_ff;
         end
      endcase
      case (cmd.slice)
         2'd0: chunk = $signed({1'b0, mac_x[15:0]});
         2'd1: chunk = $signed({1'b0, mac_x[31:16]});
         default: chunk = $signed({mac_x[MACX_W-1], mac_x[47:32]});
      endcase
   end

   assign pp = mac_g * chunk;

   always_comb begin
      case (cmd.slice)
         2'd0: pp_sh = ACC_W'(pp);
         2'd1: pp_sh = ACC_W'(pp) <<< 16;
         default: pp_sh = ACC_W'(pp) <<< 32;
      endcase
   end

   assign acc_sh = acc_ff >>> 16;
   assign sum_cl = (sum_ff < -SUM_LIM) ? -SUM_LIM : (sum_ff > SUM_LIM) ? SUM_LIM : sum_ff;
   assign sum_rnd = sum_cl[SUM_W-1] ? (sum_cl + SUM_W'(65535)) >>> 16 : sum_cl >>> 16;

   always_comb begin
      mag1 = pid_ff[PID_W-1] ? -pid_ff : pid_ff;
      mind_s = PID_W'({1'b0, mind_ff});
      if (mag1 != '0 && mag1 < mind_s) begin
         v1 = pid_ff[PID_W-1] ? -mind_s : mind_s;
      end else begin
         v1 = pid_ff;
      end
      err_abs = err_s[ERR_W-1] ? PID_W'(-err_s) : PID_W'(err_s);
      tol_s = PID_W'({1'b0, tol_ff});
      v2 = (err_abs < tol_s) ? '0 : v1;
      v3 = (v2 > PID_FULL) ? PID_FULL : (v2 < -PID_FULL) ? -PID_FULL : v2;
      mag3 = v3[PID_W-1] ? -v3 : v3;
      duty_in = (mag3 > PID_MAX) ? 8'd255 : mag3[7:0];
      dir_in = (v3 > 0) ? DIR_FWD : (v3 < 0) ? DIR_REV : DIR_STOP;
      hpid_in = (pid_ff > PID_MAX) ? 9'sd255 : (pid_ff < -PID_MAX) ? -9'sd255 :
                pid_ff[8:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RST;
         gp_ff <= '0;
         gi_ff <= '0;
         gd_ff <= '0;
         floor_ff <= FLOOR_RST;
         ceil_ff <= CEIL_RST;
         mind_ff <= '0;
         tol_ff <= TOL_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_TARGET: target_ff <= csr_wdata[15:0];
            REG_GAIN_P: gp_ff <= $signed(csr_wdata);
            REG_GAIN_I: gi_ff <= $signed(csr_wdata);
            REG_GAIN_D: gd_ff <= $signed(csr_wdata);
            REG_INT_FLOOR: floor_ff <= $signed(csr_wdata);
            REG_INT_CEIL: ceil_ff <= csr_wdata[30:0];
            REG_MIN_DUTY: mind_ff <= csr_wdata[7:0];
            REG_TOLERANCE: tol_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         status_ff <= ST_INACTIVE;
         integ_ff <= '0;
         prev_ff <= '0;
         hduty_ff <= '0;
         hdir_ff <= DIR_STOP;
         hpid_ff <= '0;
      end else begin
         if (csr_we && csr_index == REG_TARGET) begin
            integ_ff <= '0;
            prev_ff <= '0;
         end
         if (cmd.decode) begin
            case (op_ff)
               OP_ACTIVATE: begin
                  enabled_ff <= 1'b1;
                  status_ff <= ST_ACTIVE;
                  integ_ff <= '0;
                  prev_ff <= '0;
               end
               OP_DEACTIVATE: begin
                  enabled_ff <= 1'b0;
                  status_ff <= ST_INACTIVE;
                  hduty_ff <= '0;
                  hdir_ff <= DIR_STOP;
                  hpid_ff <= '0;
               end
               OP_ESTOP: begin
                  enabled_ff <= 1'b0;
                  status_ff <= ST_EMERGENCY;
                  hduty_ff <= '0;
                  hdir_ff <= DIR_STOP;
                  hpid_ff <= '0;
               end
               default: begin
                  hduty_ff <= '0;
                  hdir_ff <= DIR_STOP;
                  hpid_ff <= '0;
               end
            endcase
         end
         if (cmd.int_load) begin
            integ_ff <= int_in;
         end
         if (cmd.der_load) begin
            prev_ff <= eq_ff;
         end
         if (cmd.fin_load) begin
            hduty_ff <= duty_in;
            hdir_ff <= dir_in;
            hpid_ff <= hpid_in;
            status_ff <= ST_ACTIVE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         op_ff <= in_operation;
         dist_ff <= in_distance;
         ms_ff <= in_elapsed_ms;
      end
      if (cmd.eq_mul) begin
         eq_frac_ff <= eq_rp[40:25];
      end
      if (cmd.eq_load) begin
         eq_ff <= err_s[ERR_W-1] ? -$signed({1'b0, eq_mag}) : $signed({1'b0, eq_mag});
      end
      if (cmd.iq_load) begin
         qa_ff <= div_by_1000(eq_abs);
      end
      if (cmd.im_load) begin
         rm_ff <= 26'(ra) * 26'(ms_eff);
         qm_ff <= 33'(qa_ff) * 33'(ms_eff);
      end
      if (cmd.istep_load) begin
         step_ff <= eq_ff[EQ_W-1] ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});
      end
      if (cmd.prod_d_load) begin
         prod_ff <= PROD_W'(mul_d);
      end
      if (cmd.der_load) begin
         der_ff <= div_q[DER_W-1:0];
      end
      if (cmd.mac_step) begin
         acc_ff <= (cmd.slice == 2'd0) ? pp_sh : acc_ff + pp_sh;
      end
      if (cmd.sum_clear) begin
         sum_ff <= '0;
      end else if (cmd.sum_add) begin
         sum_ff <= sum_ff + $signed(acc_sh[SUM_W-1:0]);
      end
      if (cmd.pid_load) begin
         pid_ff <= sum_rnd[PID_W-1:0];
      end
      if (cmd.rsp_load) begin
         duty_ff <= hduty_ff;
         dir_ff <= hdir_ff;
         cst_ff <= status_ff;
         pido_ff <= hpid_ff;
      end
   end

   assign out_duty = duty_ff;
   assign out_direction = dir_ff;
   assign out_control_state = cst_ff;
   assign out_pid_output = pido_ff;
endmodule

/* sv/pdmc_ctrl.sv */
// ----------------------------------------------------------------------------
// PID controller sequencer
// Steps the datapath through error scaling, integration, derivative and the
// multiply-accumulate of the three terms, and owns the handshakes.
// ----------------------------------------------------------------------------
module pdmc_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  pdmc_pkg::pdmc_stat_type stat,
   output pdmc_pkg::pdmc_cmd_type cmd
);
   import pdmc_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic [1:0] term_ff, term_in, slice_ff, slice_in;
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         term_ff <= '0;
         slice_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         term_ff <= term_in;
         slice_ff <= slice_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      term_in = term_ff;
      slice_in = slice_ff;
      cmd = '0;
      cmd.term = term_ff;
      cmd.slice = slice_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.run_pid) begin
               state_in = S_EQ_MUL;
            end else begin
               cmd.decode = 1'b1;
               state_in = S_DONE;
            end
         end
         S_EQ_MUL: begin
            cmd.eq_mul = 1'b1;
            state_in = S_EQ_LOAD;
         end
         S_EQ_LOAD: begin
            cmd.eq_load = 1'b1;
            state_in = S_I_QUO;
         end
         S_I_QUO: begin
            cmd.iq_load = 1'b1;
            state_in = S_I_MUL;
         end
         S_I_MUL: begin
            cmd.im_load = 1'b1;
            state_in = S_I_STEP;
         end
         S_I_STEP: begin
            cmd.istep_load = 1'b1;
            state_in = S_I_LOAD;
         end
         S_I_LOAD: begin
            cmd.int_load = 1'b1;
            state_in = S_D_MUL;
         end
         S_D_MUL: begin
            cmd.prod_d_load = 1'b1;
            state_in = S_D_START;
         end
         S_D_START: begin
            cmd.div_start = 1'b1;
            state_in = S_D_DIV;
         end
         S_D_DIV: begin
            if (stat.div_done) begin
               cmd.der_load = 1'b1;
               cmd.sum_clear = 1'b1;
               term_in = 2'd0;
               slice_in = 2'd0;
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            cmd.mac_step = 1'b1;
            if (slice_ff == 2'd2) begin
               state_in = S_SUM;
            end else begin
               slice_in = slice_ff + 2'd1;
            end
         end
         S_SUM: begin
            cmd.sum_add = 1'b1;
            slice_in = 2'd0;
            if (term_ff == 2'd2) begin
               state_in = S_CLAMP;
            end else begin
               term_in = term_ff + 2'd1;
               state_in = S_MAC;
            end
         end
         S_CLAMP: begin
            cmd.pid_load = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.fin_load = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

/* sv/pid_distance_motor_control_unit.sv */
// ----------------------------------------------------------------------------
// PID distance motor control unit
// Distance-holding PID controller with a clamped integral in Q16.16.
//
// The req channel takes one item per operation: a distance sample with the
// milliseconds since the previous one, or an activate, deactivate or
// emergency-stop command. Every item yields exactly one item on the rsp
// channel with duty, direction, control state and the clamped PID output.
// The user writes csr port settings only while idle; unit does not enforce it.
//
// A command or a sample taken while inactive passes through the decode and
// done states before it presents its result. An active sample runs through
// error scaling and integral step by reciprocal multiplication, a 42-bit
// bit-serial division of the derivative by the elapsed time, then the
// multiply-accumulate for the three gain terms and the output shaping.
// One item is in work at a time; the next is accepted as soon as the unit
// returns to idle, even while the last result still waits in the output
// register. A stalled receiver holds the result; a finished item then waits
// until the output register frees.
// Synchronous reset clears the PID state, the held outputs and all settings
// to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pid_distance_motor_control_unit #(
   parameter int FULL_DUTY = pdmc_pkg::FULL_DUTY_DEF
) (
   input  logic clock,
   input  logic reset,
   pdmc_req_if.sink req_ch,
   pdmc_rsp_if.source rsp_ch,
   input  logic csr_we,
   input  logic [pdmc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pdmc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pdmc_pkg::*;

   pdmc_cmd_type cmd;
   pdmc_stat_type stat;

   pdmc_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .stat(stat),
      .cmd(cmd)
   );

   pdmc_datapath #(
      .FULL_DUTY(FULL_DUTY)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .in_operation(req_ch.operation),
      .in_distance(req_ch.distance),
      .in_elapsed_ms(req_ch.elapsed_ms),
      .cmd(cmd),
      .stat(stat),
      .out_duty(rsp_ch.duty),
      .out_direction(rsp_ch.direction),
      .out_control_state(rsp_ch.control_state),
      .out_pid_output(rsp_ch.pid_output)
   );
endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PID distance motor control testbench
// Sends samples and commands through the request channel under random bursts
// and gaps, stalls the response channel on its own pattern, and checks every
// response against an in-bench model of the controller. The settings are
// changed between phases while the unit is idle, extremes included.
// ----------------------------------------------------------------------------
module testbench;
   import pdmc_pkg::*;

   typedef struct packed {
      op_type op;
      logic [15:0] distance;
      logic [15:0] elapsed_ms;
   } cmd_item_type;

   typedef struct packed {
      logic [7:0] duty;
      logic [1:0] direction;
      logic [1:0] control_state;
      logic [8:0] pid_output;
   } motor_out_type;

   localparam int FULL = FULL_DUTY_DEF;
   localparam int IDLE_LIMIT = 20000;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pdmc_req_if req_ch ();
   pdmc_rsp_if rsp_ch ();

   pid_distance_motor_control_unit dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Model state and settings.
   longint target_cm, gp, gi, gd, int_floor, int_ceil, min_duty, tolerance;
   longint integ, prev_err;
   bit running;
   logic [1:0] ctl_state;
   motor_out_type held_out;

   cmd_item_type pending_cmds[$];
   motor_out_type expected_outs[$];
   int errors;
   int idle_cycles;
   int burst_left;
   int gap_left;
   int stall_phase;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic longint floor_shift16(longint x);
      return x >>> 16;
   endfunction

   function automatic longint gain_term(longint g, longint x);
      longint lo;
      longint hi;
      lo = g & 64'hFFFF;
      hi = (g - lo) / 65536;
      return x * hi + floor_shift16(x * lo);
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      if (v < lo) begin
         return lo;
      end
      if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

   function automatic void model_reset();
      target_cm = 2000;
      gp = 0;
      gi = 0;
      gd = 0;
      int_floor = -6553600;
      int_ceil = 6553600;
      min_duty = 0;
      tolerance = 100;
      integ = 0;
      prev_err = 0;
      running = 1'b0;
      ctl_state = ST_INACTIVE;
      held_out = '0;
   endfunction

   function automatic void model_write(reg_index_type idx, logic [31:0] val);
      case (idx)
         REG_TARGET: begin
            target_cm = longint'(val[15:0]);
            integ = 0;
            prev_err = 0;
         end
         REG_GAIN_P: gp = longint'($signed(val));
         REG_GAIN_I: gi = longint'($signed(val));
         REG_GAIN_D: gd = longint'($signed(val));
         REG_INT_FLOOR: int_floor = longint'($signed(val));
         REG_INT_CEIL: int_ceil = longint'(val[30:0]);
         REG_MIN_DUTY: min_duty = longint'(val[7:0]);
         REG_TOLERANCE: tolerance = longint'(val[15:0]);
         default: ;
      endcase
   endfunction

   function automatic motor_out_type control_step(cmd_item_type c);
      longint err, eq, ms, deriv, sum, lim, pid, v, mag;
      motor_out_type r;
      if (c.op == OP_ACTIVATE) begin
         running = 1'b1;
         ctl_state = ST_ACTIVE;
         integ = 0;
         prev_err = 0;
      end else if (c.op == OP_DEACTIVATE || c.op == OP_ESTOP || !running) begin
         if (c.op == OP_DEACTIVATE) begin
            running = 1'b0;
            ctl_state = ST_INACTIVE;
         end else if (c.op == OP_ESTOP) begin
            running = 1'b0;
            ctl_state = ST_EMERGENCY;
         end
         held_out = '0;
      end else begin
         err = target_cm - longint'(c.distance);
         eq = err * 65536 / 100;
         ms = (c.elapsed_ms == 0) ? 1 : longint'(c.elapsed_ms);
         integ = clip(integ + eq * ms / 1000, int_floor, int_ceil);
         deriv = (eq - prev_err) * 1000 / ms;
         sum = gain_term(gp, eq) + gain_term(gi, integ) + gain_term(gd, deriv);
         lim = longint'(FULL) * 65536;
         sum = clip(sum, -lim, lim);
         pid = sum / 65536;
         prev_err = eq;
         v = pid;
         mag = (v < 0) ? -v : v;
         if (mag > 0 && mag < min_duty) begin
            v = (v > 0) ? min_duty : -min_duty;
         end
         if (((err < 0) ? -err : err) < tolerance) begin
            v = 0;
         end
         v = clip(v, -FULL, FULL);
         mag = (v < 0) ? -v : v;
         held_out.duty = (mag > 255) ? 8'd255 : mag[7:0];
         held_out.direction = (v > 0) ? DIR_FWD : ((v < 0) ? DIR_REV : DIR_STOP);
         v = clip(pid, -255, 255);
         held_out.pid_output = v[8:0];
         ctl_state = ST_ACTIVE;
      end
      r = held_out;
      r.control_state = ctl_state;
      return r;
   endfunction

   // Driver: bursts of items with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid && req_ch.ready) begin
            expected_outs.push_back(control_step(pending_cmds.pop_front()));
         end
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            req_ch.valid <= 1'b1;
            req_ch.operation <= pending_cmds[0].op;
            req_ch.distance <= pending_cmds[0].distance;
            req_ch.elapsed_ms <= pending_cmds[0].elapsed_ms;
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 12);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 200);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Monitor: response stall pattern and checking.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_phase <= 0;
         idle_cycles <= 0;
      end else begin
         stall_phase <= stall_phase + 1;
         case (stall_phase[10:9])
            2'd0: rsp_ch.ready <= 1'b1;
            2'd1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2'd2: rsp_ch.ready <= (stall_phase[3:0] > 4'd10);
            default: rsp_ch.ready <= ($urandom_range(0, 1) == 0);
         endcase
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_outs.size() == 0) begin
               $display("%0t: unexpected response duty=%0d", $time, rsp_ch.duty);
               errors <= errors + 1;
            end else if (expected_outs[0] != {rsp_ch.duty, rsp_ch.direction,
                                              rsp_ch.control_state,
                                              rsp_ch.pid_output}) begin
               $display("%0t: mismatch expected duty=%0d dir=%0d state=%0d pid=%0d",
                        $time, expected_outs[0].duty, expected_outs[0].direction,
                        expected_outs[0].control_state,
                        $signed(expected_outs[0].pid_output));
               $display("%0t:          actual duty=%0d dir=%0d state=%0d pid=%0d",
                        $time, rsp_ch.duty, rsp_ch.direction, rsp_ch.control_state,
                        rsp_ch.pid_output);
               errors <= errors + 1;
               void'(expected_outs.pop_front());
            end else begin
               void'(expected_outs.pop_front());
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic write_reg(reg_index_type idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      model_write(idx, val);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_cmds.size() > 0 || req_ch.valid || expected_outs.size() > 0) begin
         @(posedge clock);
      end
      repeat (200) @(posedge clock);
   endtask

   task automatic add_cmd(op_type op, logic [15:0] d, logic [15:0] ms);
      cmd_item_type c;
      c.op = op;
      c.distance = d;
      c.elapsed_ms = ms;
      pending_cmds.push_back(c);
   endtask

   function automatic logic [15:0] rand_dist();
      case ($urandom_range(0, 5))
         0: return 16'($urandom);
         1: return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
         default: return 16'(target_cm + $urandom_range(0, 4000) - 2000);
      endcase
   endfunction

   function automatic logic [15:0] rand_ms();
      case ($urandom_range(0, 5))
         0: return 16'($urandom);
         1: return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
         default: return 16'($urandom_range(0, 100));
      endcase
   endfunction

   task automatic random_phase(int count);
      int k;
      int r;
      for (k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 4) begin
            add_cmd(OP_ACTIVATE, 16'($urandom), 16'($urandom));
         end else if (r < 6) begin
            add_cmd(OP_DEACTIVATE, 16'($urandom), 16'($urandom));
         end else if (r < 7) begin
            add_cmd(OP_ESTOP, 16'($urandom), 16'($urandom));
         end else begin
            add_cmd(OP_SAMPLE, rand_dist(), rand_ms());
         end
      end
   endtask

   task automatic random_settings();
      write_reg(REG_TARGET, $urandom);
      write_reg(REG_GAIN_P, ($urandom_range(0, 3) == 0) ? $urandom
                                                         : $signed($urandom_range(0, 2000000)) - 1000000);
      write_reg(REG_GAIN_I, ($urandom_range(0, 3) == 0) ? $urandom
                                                         : $signed($urandom_range(0, 200000)) - 100000);
      write_reg(REG_GAIN_D, ($urandom_range(0, 3) == 0) ? $urandom
                                                         : $signed($urandom_range(0, 2000)) - 1000);
      write_reg(REG_INT_FLOOR, -$urandom_range(0, 20000000));
      write_reg(REG_INT_CEIL, $urandom_range(0, 20000000));
      write_reg(REG_MIN_DUTY, $urandom_range(0, 255));
      write_reg(REG_TOLERANCE, $urandom_range(0, 300));
   endtask

   initial begin
      int ph;
      errors = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.operation = OP_SAMPLE;
      req_ch.distance = '0;
      req_ch.elapsed_ms = '0;
      rsp_ch.ready = 1'b0;
      model_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part under reset settings, then with gains.
      add_cmd(OP_SAMPLE, 16'd500, 16'd10);
      add_cmd(OP_ACTIVATE, 16'd0, 16'd0);
      add_cmd(OP_SAMPLE, 16'd2050, 16'd0);
      add_cmd(OP_SAMPLE, 16'd0, 16'hFFFF);
      add_cmd(OP_SAMPLE, 16'hFFFF, 16'd1);
      add_cmd(OP_ESTOP, 16'hFFFF, 16'hFFFF);
      add_cmd(OP_SAMPLE, 16'd100, 16'd5);
      add_cmd(OP_DEACTIVATE, 16'd0, 16'd0);
      wait_idle();
      write_reg(REG_GAIN_P, 32'h7FFF_FFFF);
      write_reg(REG_GAIN_I, 32'h8000_0000);
      write_reg(REG_GAIN_D, 32'h0000_0100);
      write_reg(REG_MIN_DUTY, 32'd255);
      write_reg(REG_INT_FLOOR, 32'h8000_0000);
      write_reg(REG_INT_CEIL, 32'h7FFF_FFFF);
      add_cmd(OP_ACTIVATE, 16'd0, 16'd0);
      add_cmd(OP_SAMPLE, 16'd0, 16'd0);
      add_cmd(OP_SAMPLE, 16'hFFFF, 16'hFFFF);
      add_cmd(OP_SAMPLE, 16'd1999, 16'd3);
      wait_idle();
      write_reg(REG_GAIN_P, 32'h0001_0000);
      write_reg(REG_GAIN_I, 32'h0000_4000);
      write_reg(REG_MIN_DUTY, 32'd40);
      write_reg(REG_TOLERANCE, 32'd0);
      write_reg(REG_INT_FLOOR, 32'd1000);
      write_reg(REG_INT_CEIL, 32'd0);
      add_cmd(OP_SAMPLE, 16'd2100, 16'd20);
      add_cmd(OP_SAMPLE, 16'd1900, 16'd20);
      add_cmd(OP_SAMPLE, 16'd2000, 16'd20);
      add_cmd(OP_SAMPLE, 16'd1000, 16'd1000);
      wait_idle();
      write_reg(REG_TARGET, 32'h0000_FFFF);
      add_cmd(OP_SAMPLE, 16'd0, 16'd7);
      wait_idle();
      write_reg(REG_TARGET, 32'd0);
      write_reg(REG_TOLERANCE, 32'h0000_FFFF);
      add_cmd(OP_SAMPLE, 16'hFFFF, 16'd1);
      add_cmd(OP_SAMPLE, 16'd5, 16'd1);
      wait_idle();

      for (ph = 0; ph < 8; ph++) begin
         random_settings();
         add_cmd(OP_ACTIVATE, 16'($urandom), 16'($urandom));
         random_phase(200);
         wait_idle();
      end

      wait_idle();
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/pdmc_pkg.sv
sv/pdmc_req_if.sv
sv/pdmc_rsp_if.sv
sv/pdmc_div.sv
sv/pdmc_datapath.sv
sv/pdmc_ctrl.sv
sv/pid_distance_motor_control_unit.sv
tb/testbench.sv
